// ===== src/paired_line_pixel_stepper_core_defines.svh =====
// Assertion macros shared by the line stepper modules.
`ifndef PAIRED_LINE_PIXEL_STEPPER_CORE_DEFINES_SVH
`define PAIRED_LINE_PIXEL_STEPPER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/plps_pkg.sv =====
package plps_pkg;

  // Coordinate width of the input endpoints and offsets.
  localparam int CoordW   = 13;
  localparam int PosW     = CoordW + 1;
  localparam int ErrW     = CoordW + 5;
  localparam int DecW     = CoordW + 3;
  localparam int StepW    = 3;
  localparam int StepMax  = 4;
  localparam int ScrW     = 13;
  localparam int ScrMax   = 4096;
  localparam int OffW     = 12;
  localparam int OutW     = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  // Compare width for four times the span against up to three screen sizes.
  localparam int CmpW = (CoordW + 2 > ScrW + 2) ? CoordW + 2 : ScrW + 2;
  // Width of a coordinate after the screen offset is added.
  localparam int PxW  = (PosW > OffW + 1) ? PosW + 1 : OffW + 2;

  // Division by three through a reciprocal, exact for any CoordW-bit value.
  localparam int DivShift = CoordW + 4;
  localparam int RecipW   = CoordW + 3;
  localparam int Recip3   = (1 << DivShift) / 3 + 1;
  localparam int ProdW    = CoordW + RecipW;

  localparam int ScrWidthRst  = 640;
  localparam int ScrHeightRst = 480;

  localparam logic OpStart = 1'b0;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   delta_t;
  typedef logic        [CoordW-1:0] mag_t;
  typedef logic signed [PosW-1:0]   pos_t;
  typedef logic signed [ErrW-1:0]   err_t;
  typedef logic        [DecW-1:0]   dec_t;
  typedef logic        [StepW-1:0]  step_t;
  typedef logic        [ScrW-1:0]   scr_t;
  typedef logic        [OffW-1:0]   off_t;
  typedef logic        [OutW-1:0]   out_t;
  typedef logic        [CmpW-1:0]   cmp_t;
  typedef logic signed [PxW-1:0]    px_t;
  typedef logic        [RecipW-1:0] recip_t;
  typedef logic        [ProdW-1:0]  prod_t;
  typedef logic        [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic        [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_X_OFFSET      = 2'd2,
    CFG_Y_OFFSET      = 2'd3
  } plps_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_SETUP4,
    ST_ADVANCE,
    ST_ADJUST,
    ST_EMIT
  } plps_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup1;
    logic setup2;
    logic setup3;
    logic setup4;
    logic advance;
    logic adjust;
    logic emit;
  } plps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_start;
    logic steps_zero;
    logic err_neg;
    logic out_free;
  } plps_status_t;

  // Effective configuration seen by the datapath.
  typedef struct packed {
    scr_t eff_width;
    scr_t eff_height;
    off_t x_offset;
    off_t y_offset;
  } plps_cfg_t;

  // One clipped output point.
  typedef struct packed {
    out_t x;
    out_t y;
    logic on_screen;
  } plps_point_t;

endpackage

// ===== src/plps_datapath.sv =====
`include "paired_line_pixel_stepper_core_defines.svh"

module plps_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  plps_pkg::plps_cmd_t    cmd_i,
  output plps_pkg::plps_status_t status_o,
  input  plps_pkg::plps_cfg_t    cfg_i,
  input  logic                   op_i,
  input  plps_pkg::coord_t       from_x_i,
  input  plps_pkg::coord_t       from_y_i,
  input  plps_pkg::coord_t       to_x_i,
  input  plps_pkg::coord_t       to_y_i,
  input  plps_pkg::coord_t       pair_dx_i,
  input  plps_pkg::coord_t       pair_dy_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output plps_pkg::out_t         first_x_o,
  output plps_pkg::out_t         first_y_o,
  output logic                   first_inside_o,
  output plps_pkg::out_t         second_x_o,
  output plps_pkg::out_t         second_y_o,
  output logic                   second_inside_o,
  output logic                   done_res_o
);

  // Latched input item.
  logic             op_q;
  plps_pkg::coord_t fx_q, fy_q, tx_q, ty_q, pdx_q, pdy_q;

  // Spans of the first line, from the first setup cycle.
  plps_pkg::mag_t adx_q, ady_q;
  logic           dx_neg_q, dx_pos_q, dy_neg_q, dy_pos_q;

  // Line state.
  plps_pkg::pos_t  one_x_q, one_y_q, two_x_q, two_y_q;
  logic            major_x_q, minor_neg_q;
  plps_pkg::step_t step_q;
  plps_pkg::err_t  err_q;
  plps_pkg::dec_t  dec_q;
  plps_pkg::mag_t  inc_q, minor_q, steps_q;

  // Output register.
  logic                  out_valid_q;
  plps_pkg::plps_point_t first_q, second_q;
  logic                  done_q;

  // Setup cycle one: signed spans and their magnitudes.
  plps_pkg::delta_t dx, dy;
  plps_pkg::mag_t   adx, ady;

  always_comb begin
    dx  = plps_pkg::delta_t'(tx_q) - plps_pkg::delta_t'(fx_q);
    dy  = plps_pkg::delta_t'(ty_q) - plps_pkg::delta_t'(fy_q);
    adx = dx[plps_pkg::CoordW] ? plps_pkg::mag_t'(-dx) : plps_pkg::mag_t'(dx);
    ady = dy[plps_pkg::CoordW] ? plps_pkg::mag_t'(-dy) : plps_pkg::mag_t'(dy);
  end

  // Setup cycle two: pick the major axis and order the endpoints.
  logic             major_x, swapped, minor_neg;
  plps_pkg::coord_t start_x, start_y;
  plps_pkg::mag_t   span, minor;

  always_comb begin
    major_x   = adx_q > ady_q;
    swapped   = major_x ? dx_neg_q : dy_neg_q;
    start_x   = swapped ? tx_q : fx_q;
    start_y   = swapped ? ty_q : fy_q;
    span      = major_x ? adx_q : ady_q;
    minor     = major_x ? ady_q : adx_q;
    if (major_x) begin
      minor_neg = swapped ? !dy_neg_q : !dy_pos_q;
    end else begin
      minor_neg = swapped ? !dx_neg_q : !dx_pos_q;
    end
  end

  // Setup cycle three: the major step is floor(4*span/screen)+1, capped at four.
  plps_pkg::scr_t  screen;
  plps_pkg::cmp_t  span4, scr1, scr2, scr3;
  plps_pkg::step_t step_d;

  always_comb begin
    screen = major_x_q ? cfg_i.eff_width : cfg_i.eff_height;
    span4  = plps_pkg::cmp_t'({inc_q, 2'b00});
    scr1   = plps_pkg::cmp_t'(screen);
    scr2   = plps_pkg::cmp_t'({screen, 1'b0});
    scr3   = scr1 + scr2;
    step_d = plps_pkg::step_t'(1)
           + plps_pkg::step_t'(span4 >= scr1)
           + plps_pkg::step_t'(span4 >= scr2)
           + plps_pkg::step_t'(span4 >= scr3);
  end

  // Setup cycle four: step count and error decrement for the chosen step.
  plps_pkg::mag_t  span_m1, div3, steps_d;
  plps_pkg::prod_t prod;
  plps_pkg::dec_t  dec_d;

  always_comb begin
    span_m1 = (inc_q == '0) ? '0 : plps_pkg::mag_t'(inc_q - plps_pkg::mag_t'(1));
    prod    = plps_pkg::prod_t'(span_m1)
            * plps_pkg::prod_t'(plps_pkg::recip_t'(plps_pkg::Recip3));
    div3    = plps_pkg::mag_t'(prod >> plps_pkg::DivShift);
    unique case (step_q)
      plps_pkg::step_t'(1): begin
        steps_d = span_m1;
        dec_d   = plps_pkg::dec_t'(minor_q);
      end
      plps_pkg::step_t'(2): begin
        steps_d = span_m1 >> 1;
        dec_d   = plps_pkg::dec_t'({minor_q, 1'b0});
      end
      plps_pkg::step_t'(3): begin
        steps_d = div3;
        dec_d   = plps_pkg::dec_t'(minor_q) + plps_pkg::dec_t'({minor_q, 1'b0});
      end
      plps_pkg::step_t'(4): begin
        steps_d = span_m1 >> 2;
        dec_d   = plps_pkg::dec_t'({minor_q, 2'b00});
      end
      default: begin
        steps_d = '0;
        dec_d   = '0;
      end
    endcase
  end

  // Stepping increments along the major and minor axes.
  plps_pkg::pos_t step_s, minor_dir;

  always_comb begin
    step_s    = plps_pkg::pos_t'(step_q);
    minor_dir = minor_neg_q ? '1 : plps_pkg::pos_t'(1);
  end

  // Offset a point and clip it against the screen.
  function automatic plps_pkg::plps_point_t clip_point(
    input plps_pkg::pos_t x,
    input plps_pkg::pos_t y,
    input plps_pkg::plps_cfg_t cfg
  );
    plps_pkg::px_t         px, py;
    logic                  in_x, in_y;
    plps_pkg::plps_point_t pt;
    px           = plps_pkg::px_t'(x) + plps_pkg::px_t'(cfg.x_offset);
    py           = plps_pkg::px_t'(y) + plps_pkg::px_t'(cfg.y_offset);
    in_x         = !px[plps_pkg::PxW-1] && (px < plps_pkg::px_t'(cfg.eff_width));
    in_y         = !py[plps_pkg::PxW-1] && (py < plps_pkg::px_t'(cfg.eff_height));
    pt.on_screen = in_x && in_y;
    pt.x         = pt.on_screen ? px[plps_pkg::OutW-1:0] : '0;
    pt.y         = pt.on_screen ? py[plps_pkg::OutW-1:0] : '0;
    return pt;
  endfunction

  // Input latch and span registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      fx_q  <= from_x_i;
      fy_q  <= from_y_i;
      tx_q  <= to_x_i;
      ty_q  <= to_y_i;
      pdx_q <= pair_dx_i;
      pdy_q <= pair_dy_i;
    end
    if (cmd_i.setup1) begin
      adx_q    <= adx;
      ady_q    <= ady;
      dx_neg_q <= dx[plps_pkg::CoordW];
      dx_pos_q <= !dx[plps_pkg::CoordW] && (dx != '0);
      dy_neg_q <= dy[plps_pkg::CoordW];
      dy_pos_q <= !dy[plps_pkg::CoordW] && (dy != '0);
    end
  end

  // Line state: setup loads it, advance and adjust walk it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_x_q     <= '0;
      one_y_q     <= '0;
      two_x_q     <= '0;
      two_y_q     <= '0;
      major_x_q   <= 1'b0;
      minor_neg_q <= 1'b0;
      step_q      <= plps_pkg::step_t'(1);
      err_q       <= '0;
      dec_q       <= '0;
      inc_q       <= '0;
      minor_q     <= '0;
      steps_q     <= '0;
    end else begin
      if (cmd_i.setup2) begin
        one_x_q     <= plps_pkg::pos_t'(start_x);
        one_y_q     <= plps_pkg::pos_t'(start_y);
        two_x_q     <= plps_pkg::pos_t'(start_x) + plps_pkg::pos_t'(pdx_q);
        two_y_q     <= plps_pkg::pos_t'(start_y) + plps_pkg::pos_t'(pdy_q);
        major_x_q   <= major_x;
        minor_neg_q <= minor_neg;
        inc_q       <= span;
        minor_q     <= minor;
        err_q       <= plps_pkg::err_t'(span >> 1);
      end
      if (cmd_i.setup3) begin
        step_q <= step_d;
      end
      if (cmd_i.setup4) begin
        steps_q <= steps_d;
        dec_q   <= dec_d;
      end
      if (cmd_i.advance) begin
        steps_q <= steps_q - plps_pkg::mag_t'(1);
        err_q   <= err_q - plps_pkg::err_t'(dec_q);
        if (major_x_q) begin
          one_x_q <= one_x_q + step_s;
          two_x_q <= two_x_q + step_s;
        end else begin
          one_y_q <= one_y_q + step_s;
          two_y_q <= two_y_q + step_s;
        end
      end
      if (cmd_i.adjust) begin
        err_q <= err_q + plps_pkg::err_t'(inc_q);
        if (major_x_q) begin
          one_y_q <= one_y_q + minor_dir;
          two_y_q <= two_y_q + minor_dir;
        end else begin
          one_x_q <= one_x_q + minor_dir;
          two_x_q <= two_x_q + minor_dir;
        end
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      first_q  <= clip_point(one_x_q, one_y_q, cfg_i);
      second_q <= clip_point(two_x_q, two_y_q, cfg_i);
      done_q   <= (steps_q == '0);
    end
  end

  // Status back to the controller.
  always_comb begin
    status_o.op_start   = (op_q == plps_pkg::OpStart);
    status_o.steps_zero = (steps_q == '0);
    status_o.err_neg    = err_q[plps_pkg::ErrW-1] && (inc_q != '0);
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign first_x_o       = first_q.x;
  assign first_y_o       = first_q.y;
  assign first_inside_o  = first_q.on_screen;
  assign second_x_o      = second_q.x;
  assign second_y_o      = second_q.y;
  assign second_inside_o = second_q.on_screen;
  assign done_res_o      = done_q;

  // A point is only emitted once the error term is back in range.
  `PLPS_ASSERT_SAME(a_emit_err_settled, clk_i, rst_ni, cmd_i.emit, !err_q[plps_pkg::ErrW-1], "emit with negative error term")
  // The major step stays between one and four.
  `PLPS_ASSERT_SAME(a_step_range, clk_i, rst_ni, 1'b1, (step_q != '0) && (step_q <= plps_pkg::step_t'(plps_pkg::StepMax)), "major step out of range")

endmodule

// ===== src/plps_ctrl.sv =====
`include "paired_line_pixel_stepper_core_defines.svh"

module plps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  plps_pkg::plps_status_t status_i,
  output plps_pkg::plps_cmd_t    cmd_o
);

  plps_pkg::plps_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = plps_pkg::ST_DECODE;
        end
      end
      plps_pkg::ST_DECODE: begin
        priority if (status_i.op_start) begin
          state_d = plps_pkg::ST_SETUP1;
        end else if (status_i.steps_zero) begin
          state_d = plps_pkg::ST_IDLE;
        end else begin
          state_d = plps_pkg::ST_ADVANCE;
        end
      end
      plps_pkg::ST_SETUP1:  state_d = plps_pkg::ST_SETUP2;
      plps_pkg::ST_SETUP2:  state_d = plps_pkg::ST_SETUP3;
      plps_pkg::ST_SETUP3:  state_d = plps_pkg::ST_SETUP4;
      plps_pkg::ST_SETUP4:  state_d = plps_pkg::ST_IDLE;
      plps_pkg::ST_ADVANCE: state_d = plps_pkg::ST_ADJUST;
      plps_pkg::ST_ADJUST: begin
        if (!status_i.err_neg) begin
          state_d = plps_pkg::ST_EMIT;
        end
      end
      plps_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = plps_pkg::ST_IDLE;
        end
      end
      default: state_d = plps_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      plps_pkg::ST_IDLE:    cmd_o.load    = in_valid_i;
      plps_pkg::ST_SETUP1:  cmd_o.setup1  = 1'b1;
      plps_pkg::ST_SETUP2:  cmd_o.setup2  = 1'b1;
      plps_pkg::ST_SETUP3:  cmd_o.setup3  = 1'b1;
      plps_pkg::ST_SETUP4:  cmd_o.setup4  = 1'b1;
      plps_pkg::ST_ADVANCE: cmd_o.advance = 1'b1;
      plps_pkg::ST_ADJUST:  cmd_o.adjust  = status_i.err_neg;
      plps_pkg::ST_EMIT:    cmd_o.emit    = status_i.out_free;
      default:              cmd_o         = '0;
    endcase
  end

  assign in_stall_o = (state_q != plps_pkg::ST_IDLE);

  // At most one datapath command per cycle.
  `PLPS_ASSERT_SAME(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd_o), "several datapath commands at once")
  // A step is only advanced when steps remain.
  `PLPS_ASSERT_SAME(a_advance_has_steps, clk_i, rst_ni, state_q == plps_pkg::ST_ADVANCE, !status_i.steps_zero, "advance with no steps left")

endmodule

// ===== src/paired_line_pixel_stepper_core.sv =====
// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   op, from_x/y, to_x/y, pair_dx/dy
// out       out_valid_o / out_stall_i first_x/y/inside, second_x/y/inside, done_res
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Start item: decode and four setup states before the next accept.
// Step item: decode, advance, an adjust pass for each minor-axis move (up to the major
// step) made by the single error-term adder that walks those moves, then emit.
// A step with nothing left is dropped after decode and gives no result.
// A result waits in the output register; a full register stalled downstream holds
// the next step in its emit state. Reset clears control, step count and output valid.

module paired_line_pixel_stepper_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  plps_pkg::coord_t    from_x_i,
  input  plps_pkg::coord_t    from_y_i,
  input  plps_pkg::coord_t    to_x_i,
  input  plps_pkg::coord_t    to_y_i,
  input  plps_pkg::coord_t    pair_dx_i,
  input  plps_pkg::coord_t    pair_dy_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plps_pkg::out_t      first_x_o,
  output plps_pkg::out_t      first_y_o,
  output logic                first_inside_o,
  output plps_pkg::out_t      second_x_o,
  output plps_pkg::out_t      second_y_o,
  output logic                second_inside_o,
  output logic                done_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  plps_pkg::cfg_idx_t  cfg_index_i,
  input  plps_pkg::cfg_data_t cfg_data_i
);

  plps_pkg::scr_t         width_q, height_q;
  plps_pkg::off_t         xoff_q, yoff_q;
  plps_pkg::plps_cfg_t    cfg;
  plps_pkg::plps_cmd_t    cmd;
  plps_pkg::plps_status_t status;

  // Screen size of zero counts as one, above the maximum as the maximum.
  function automatic plps_pkg::scr_t eff_size(input plps_pkg::scr_t size);
    plps_pkg::scr_t r;
    priority if (size == '0) begin
      r = plps_pkg::scr_t'(1);
    end else if (size > plps_pkg::scr_t'(plps_pkg::ScrMax)) begin
      r = plps_pkg::scr_t'(plps_pkg::ScrMax);
    end else begin
      r = size;
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= plps_pkg::scr_t'(plps_pkg::ScrWidthRst);
      height_q <= plps_pkg::scr_t'(plps_pkg::ScrHeightRst);
      xoff_q   <= '0;
      yoff_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        plps_pkg::CFG_SCREEN_WIDTH:  width_q  <= plps_pkg::scr_t'(cfg_data_i);
        plps_pkg::CFG_SCREEN_HEIGHT: height_q <= plps_pkg::scr_t'(cfg_data_i);
        plps_pkg::CFG_X_OFFSET:      xoff_q   <= plps_pkg::off_t'(cfg_data_i);
        plps_pkg::CFG_Y_OFFSET:      yoff_q   <= plps_pkg::off_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.eff_width  = eff_size(width_q);
    cfg.eff_height = eff_size(height_q);
    cfg.x_offset   = xoff_q;
    cfg.y_offset   = yoff_q;
  end

  plps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  plps_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_i           (cfg),
    .op_i            (op_i),
    .from_x_i        (from_x_i),
    .from_y_i        (from_y_i),
    .to_x_i          (to_x_i),
    .to_y_i          (to_y_i),
    .pair_dx_i       (pair_dx_i),
    .pair_dy_i       (pair_dy_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .first_x_o       (first_x_o),
    .first_y_o       (first_y_o),
    .first_inside_o  (first_inside_o),
    .second_x_o      (second_x_o),
    .second_y_o      (second_y_o),
    .second_inside_o (second_inside_o),
    .done_res_o      (done_res_o)
  );

endmodule

// ===== dv/paired_line_pixel_stepper_core_tb.sv =====
module paired_line_pixel_stepper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plps_pkg::*;

  localparam logic OpStep    = ~OpStart;
  localparam int   SettleCyc = 16;
  localparam int   GuardMax  = 64;

  // One command on the input channel.
  typedef struct {
    logic   op;
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    coord_t pair_dx;
    coord_t pair_dy;
  } line_cmd_t;

  // The two clipped points and the done flag of one step.
  typedef struct {
    plps_point_t first_pt;
    plps_point_t second_pt;
    logic        done;
  } pixel_pair_t;

  logic      clk = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall_o;
  logic      op;
  coord_t    from_x;
  coord_t    from_y;
  coord_t    to_x;
  coord_t    to_y;
  coord_t    pair_dx;
  coord_t    pair_dy;
  logic      out_valid_o;
  logic      out_stall;
  out_t      first_x_o;
  out_t      first_y_o;
  logic      first_inside_o;
  out_t      second_x_o;
  out_t      second_y_o;
  logic      second_inside_o;
  logic      done_res_o;
  logic      cfg_valid;
  logic      cfg_ready_o;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  // Predicted configuration.
  int scr_w = ScrWidthRst;
  int scr_h = ScrHeightRst;
  int off_x = 0;
  int off_y = 0;

  // Predicted stepping state of the line pair.
  int pos1_x    = 0;
  int pos1_y    = 0;
  int pos2_x    = 0;
  int pos2_y    = 0;
  bit along_x   = 1'b0;
  int stride    = 1;
  bit minor_neg = 1'b0;
  int err_acc   = 0;
  int err_sub   = 0;
  int err_add   = 0;
  int remaining = 0;

  pixel_pair_t pixel_q[$];

  // Idling controls and run statistics.
  int unsigned gap_pct     = 20;
  int unsigned stall_pct   = 20;
  int unsigned hold_cycles = 0;
  int          errors      = 0;
  int          items_done  = 0;
  int          starts_sent = 0;
  int          steps_sent  = 0;
  int          results_ok  = 0;
  int          cfg_writes  = 0;

  paired_line_pixel_stepper_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .op_i           (op),
    .from_x_i       (from_x),
    .from_y_i       (from_y),
    .to_x_i         (to_x),
    .to_y_i         (to_y),
    .pair_dx_i      (pair_dx),
    .pair_dy_i      (pair_dy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .first_x_o      (first_x_o),
    .first_y_o      (first_y_o),
    .first_inside_o (first_inside_o),
    .second_x_o     (second_x_o),
    .second_y_o     (second_y_o),
    .second_inside_o(second_inside_o),
    .done_res_o     (done_res_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Screen sizes of zero act as one, and sizes above the maximum are capped.
  function automatic int screen_size(int r);
    if (r == 0) return 1;
    if (r > ScrMax) return ScrMax;
    return r;
  endfunction

  // Adds the screen offset and clips the point against the screen.
  function automatic plps_point_t clip_point(int x, int y);
    plps_point_t p;
    int px;
    int py;
    px = x + off_x;
    py = y + off_y;
    p = '0;
    if (px >= 0 && px < screen_size(scr_w) && py >= 0 && py < screen_size(scr_h)) begin
      p.x         = px[OutW-1:0];
      p.y         = py[OutW-1:0];
      p.on_screen = 1'b1;
    end
    return p;
  endfunction

  // Updates the predicted state for one command; returns 1 when it yields a result.
  function automatic bit predict_pixels(input line_cmd_t c, output pixel_pair_t r);
    int fx;
    int fy;
    int tx;
    int ty;
    int span;
    int minor;
    int scr;
    int t;
    int dir;
    int guard;
    r.first_pt  = '0;
    r.second_pt = '0;
    r.done      = 1'b0;
    if (c.op == OpStart) begin
      fx = c.from_x;
      fy = c.from_y;
      tx = c.to_x;
      ty = c.to_y;
      // Ties go to the y-major branch.
      along_x = abs_int(tx - fx) > abs_int(ty - fy);
      if (along_x) begin
        if (fx > tx) begin
          t = fx; fx = tx; tx = t;
          t = fy; fy = ty; ty = t;
        end
        span      = tx - fx;
        minor     = abs_int(ty - fy);
        minor_neg = !(ty > fy);
        scr       = screen_size(scr_w);
      end else begin
        if (fy > ty) begin
          t = fx; fx = tx; tx = t;
          t = fy; fy = ty; ty = t;
        end
        span      = ty - fy;
        minor     = abs_int(tx - fx);
        minor_neg = !(tx > fx);
        scr       = screen_size(scr_h);
      end
      stride = span * 4 / scr + 1;
      if (stride > StepMax) stride = StepMax;
      remaining = (span > 0) ? (span - 1) / stride : 0;
      err_sub   = minor * stride;
      err_add   = span;
      err_acc   = span / 2;
      pos1_x    = fx;
      pos1_y    = fy;
      pos2_x    = fx + int'(c.pair_dx);
      pos2_y    = fy + int'(c.pair_dy);
      return 1'b0;
    end
    // A step with nothing left is dropped.
    if (remaining <= 0) return 1'b0;
    remaining--;
    dir = minor_neg ? -1 : 1;
    if (along_x) begin
      pos1_x += stride;
      pos2_x += stride;
    end else begin
      pos1_y += stride;
      pos2_y += stride;
    end
    err_acc -= err_sub;
    for (guard = 0; err_acc < 0 && err_add > 0 && guard < GuardMax; guard++) begin
      err_acc += err_add;
      if (along_x) begin
        pos1_y += dir;
        pos2_y += dir;
      end else begin
        pos1_x += dir;
        pos2_x += dir;
      end
    end
    r.first_pt  = clip_point(pos1_x, pos1_y);
    r.second_pt = clip_point(pos2_x, pos2_y);
    r.done      = (remaining == 0);
    return 1'b1;
  endfunction

  // Offers one command, waits for its transfer and records the expected result.
  task automatic send_item(input line_cmd_t c);
    pixel_pair_t r;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= c.op;
    from_x   <= c.from_x;
    from_y   <= c.from_y;
    to_x     <= c.to_x;
    to_y     <= c.to_y;
    pair_dx  <= c.pair_dx;
    pair_dy  <= c.pair_dy;
    do @(negedge clk); while (in_stall_o);
    @(posedge clk);
    if (c.op == OpStart) begin
      starts_sent++;
      items_done++;
    end else begin
      steps_sent++;
    end
    if (predict_pixels(c, r)) begin
      pixel_q.push_back(r);
      items_done++;
    end
  endtask

  task automatic send_start(int fx, int fy, int tx, int ty, int pdx, int pdy);
    line_cmd_t c;
    c.op      = OpStart;
    c.from_x  = coord_t'(fx);
    c.from_y  = coord_t'(fy);
    c.to_x    = coord_t'(tx);
    c.to_y    = coord_t'(ty);
    c.pair_dx = coord_t'(pdx);
    c.pair_dy = coord_t'(pdy);
    send_item(c);
  endtask

  // Step commands carry random junk in the unused fields.
  task automatic send_steps(int n);
    line_cmd_t c;
    repeat (n) begin
      c.op      = OpStep;
      c.from_x  = coord_t'($urandom);
      c.from_y  = coord_t'($urandom);
      c.to_x    = coord_t'($urandom);
      c.to_y    = coord_t'($urandom);
      c.pair_dx = coord_t'($urandom);
      c.pair_dy = coord_t'($urandom);
      send_item(c);
    end
  endtask

  // Holds the input idle until every pending result is back and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixel_q.size() != 0);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(plps_cfg_idx_e idx, cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready_o);
    @(posedge clk);
    case (idx)
      CFG_SCREEN_WIDTH:  scr_w = data;
      CFG_SCREEN_HEIGHT: scr_h = data;
      CFG_X_OFFSET:      off_x = data[OffW-1:0];
      CFG_Y_OFFSET:      off_y = data[OffW-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(int w, int h, int xo, int yo);
    settle();
    write_reg(CFG_SCREEN_WIDTH, cfg_data_t'(w));
    write_reg(CFG_SCREEN_HEIGHT, cfg_data_t'(h));
    write_reg(CFG_X_OFFSET, cfg_data_t'(xo));
    write_reg(CFG_Y_OFFSET, cfg_data_t'(yo));
  endtask

  // Random start near the visible area, or anywhere in the coordinate range.
  function automatic line_cmd_t random_start(int wide_pct);
    line_cmd_t c;
    int bx;
    int by;
    int len;
    c.op = OpStart;
    if ($urandom_range(0, 99) < wide_pct) begin
      c.from_x  = coord_t'($urandom);
      c.from_y  = coord_t'($urandom);
      c.to_x    = coord_t'($urandom);
      c.to_y    = coord_t'($urandom);
      c.pair_dx = coord_t'($urandom);
      c.pair_dy = coord_t'($urandom);
    end else begin
      len = ($urandom_range(0, 7) == 0) ? 300 : 24;
      bx  = int'($urandom_range(0, screen_size(scr_w) + 40)) - 20 - off_x;
      by  = int'($urandom_range(0, screen_size(scr_h) + 40)) - 20 - off_y;
      c.from_x  = coord_t'(bx);
      c.from_y  = coord_t'(by);
      c.to_x    = coord_t'(bx + int'($urandom_range(0, 2 * len)) - len);
      c.to_y    = coord_t'(by + int'($urandom_range(0, 2 * len)) - len);
      c.pair_dx = coord_t'(int'($urandom_range(0, 60)) - 30);
      c.pair_dy = coord_t'(int'($urandom_range(0, 60)) - 30);
    end
    return c;
  endfunction

  // Line pairs stepped mostly to completion; some are cut short or over-stepped.
  task automatic run_line_pairs(int n_items, int wide_pct);
    int base;
    int n;
    base = items_done;
    while (items_done - base < n_items) begin
      send_item(random_start(wide_pct));
      n = remaining;
      if ($urandom_range(0, 3) == 0) n++;
      if (n > 40) n = $urandom_range(1, 40);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
      send_steps(n);
    end
  endtask

  task automatic test_directed();
    // Short x-major line run to its end, then one step too many.
    send_start(0, 0, 3, 1, 10, 10);
    send_steps(3);
    // Equal spans take the y-major branch.
    send_start(5, 5, 8, 8, -3, 2);
    send_steps(3);
    // Reversed endpoints with the minor axis running down, x major.
    send_start(10, 18, 2, 20, 0, 40);
    send_steps(2);
    // Reversed endpoints with the minor axis running down, y major.
    send_start(1, 9, 3, 2, 7, -1);
    send_steps(2);
    // Coincident endpoints give no steps.
    send_start(7, 7, 7, 7, 1, 1);
    send_steps(1);
    // Full-range line: the decimation saturates and the points are off screen.
    send_start(-4096, -4096, 4095, 4095, 4095, -4096);
    send_steps(3);
  endtask

  task automatic test_output_hold();
    // The receiver holds off long enough for the block to stall its input.
    settle();
    send_start(0, 0, 600, 20, 5, 5);
    hold_cycles = 400;
    send_steps(30);
    settle();
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      run_line_pairs(15, 10);
      settle();
    end
  endtask

  task automatic test_config_sweep();
    apply_setting(0, 0, 0, 0);
    run_line_pairs(120, 10);
    apply_setting(8191, 8191, 13'h1FFF, 13'h1FFF);
    run_line_pairs(120, 10);
    apply_setting(4096, 4096, 0, 4095);
    run_line_pairs(120, 10);
    apply_setting(1, 4097, 100, 0);
    run_line_pairs(120, 10);
    apply_setting(64, 48, 10, 20);
    run_line_pairs(120, 10);
    repeat (2) begin
      apply_setting($urandom_range(1, 8191), $urandom_range(1, 8191),
                    $urandom_range(0, 8191), $urandom_range(0, 8191));
      run_line_pairs(120, 10);
    end
  endtask

  task automatic test_steady_stream();
    // Closing stretch with both sides running flat out.
    apply_setting(320, 240, 5, 7);
    gap_pct   = 0;
    stall_pct = 0;
    run_line_pairs(350, 5);
  endtask

  // Receiver stall: random bursts, or one long hold on request.
  initial begin : receiver_stall
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [OutW-1:0] want, logic [OutW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Outputs settle after the rising edge, so a transfer is decided at the falling edge.
  always @(negedge clk) begin
    pixel_pair_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall === 1'b0) begin
      if (pixel_q.size() == 0) begin
        $error("result transfer with no result expected");
        errors++;
      end else begin
        want = pixel_q.pop_front();
        check_field("first_x", want.first_pt.x, first_x_o);
        check_field("first_y", want.first_pt.y, first_y_o);
        check_field("first_inside", want.first_pt.on_screen, first_inside_o);
        check_field("second_x", want.second_pt.x, second_x_o);
        check_field("second_y", want.second_pt.y, second_y_o);
        check_field("second_inside", want.second_pt.on_screen, second_inside_o);
        check_field("done_res", want.done, done_res_o);
        results_ok++;
      end
    end
  end

  initial begin
    #6_000_000;
    $display("FAIL paired_line_pixel_stepper_core");
    $finish;
  end

  initial begin
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    op        <= OpStart;
    from_x    <= '0;
    from_y    <= '0;
    to_x      <= '0;
    to_y      <= '0;
    pair_dx   <= '0;
    pair_dy   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    test_output_hold();
    test_sender_pause();
    test_config_sweep();
    test_steady_stream();
    settle();

    $display("Run covered %0d line pair starts, %0d step transfers and %0d register writes.",
             starts_sent, steps_sent, cfg_writes);
    $display("%0d result transfers were checked field by field.", results_ok);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("PASS paired_line_pixel_stepper_core");
    end else begin
      $display("FAIL paired_line_pixel_stepper_core");
    end
    $finish;
  end

endmodule
